// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/eapc_pkg.sv =====
// Types, constants and helper functions of the actuator position controller.
package eapc_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [3:0]  STABLE_TICKS = 4'd10;
    localparam logic [13:0] PHASE_CAP    = 14'd5000;
    localparam logic [4:0]  PAUSE_MAX    = 5'd31;

    localparam logic [1:0] CODE_TOP      = 2'd0;
    localparam logic [1:0] CODE_MID_HIGH = 2'd1;
    localparam logic [1:0] CODE_BOTTOM   = 2'd2;
    localparam logic [1:0] CODE_MID_LOW  = 2'd3;

    localparam logic [1:0] POS_BOTTOM = 2'd0;
    localparam logic [1:0] POS_MID    = 2'd1;
    localparam logic [1:0] POS_TOP    = 2'd2;
    localparam logic [1:0] EDGE_NONE  = 2'd3;
    localparam logic [1:0] TARGET_KEEP = 2'd3;

    localparam logic [2:0] HISTORY_NONE = 3'd7;
    localparam logic [2:0] LAST_NONE    = 3'd7;

    localparam logic [1:0] PAUSE_ON  = 2'd1;
    localparam logic [1:0] PAUSE_OFF = 2'd2;

    localparam logic [2:0] CFG_TICK_MS        = 3'd0;
    localparam logic [2:0] CFG_SENSOR_LOST_MS = 3'd1;
    localparam logic [2:0] CFG_OVERCURRENT_MS = 3'd2;
    localparam logic [2:0] CFG_DEAD_TIME_MS   = 3'd3;
    localparam logic [2:0] CFG_REVERSE_MS     = 3'd4;
    localparam logic [2:0] CFG_PWM_START      = 3'd5;
    localparam logic [2:0] CFG_PWM_FULL       = 3'd6;
    localparam logic [2:0] CFG_PWM_RAMP_STEP  = 3'd7;

    typedef enum logic [1:0] {
        ACT_STOP = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } action_t;

    typedef struct packed {
        logic       restart_homing;
        logic [1:0] pause_event;
        logic [1:0] target_position;
        logic       set_target;
        logic       over_current_active;
        logic [1:0] encoder_code;
    } item_t;

    typedef struct packed {
        logic       overcurrent_fault;
        logic       sensor_fault;
        logic       locked;
        logic       homed;
        logic       at_bottom;
        logic       at_top;
        logic [1:0] position_now;
        logic [9:0] pwm_duty;
        logic       drive_up;
        logic       motor_on;
    } result_t;

    typedef struct packed {
        logic [7:0]  tick_ms;
        logic [15:0] sensor_lost_ms;
        logic [15:0] overcurrent_ms;
        logic [12:0] dead_time_ms;
        logic [12:0] reverse_ms;
        logic [9:0]  pwm_start;
        logic [9:0]  pwm_full;
        logic [9:0]  pwm_ramp_step;
    } cfg_t;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

    function automatic logic [15:0] sat16_add(input logic [15:0] a, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {9'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [1:0] edge_position(input logic [2:0] a, input logic [1:0] b);
        logic [1:0] r;
        r = EDGE_NONE;
        if ((a == {1'b0, CODE_BOTTOM} && b == CODE_MID_LOW) ||
            (a == {1'b0, CODE_MID_LOW} && b == CODE_BOTTOM))
            r = POS_BOTTOM;
        else if ((a == {1'b0, CODE_MID_LOW} && b == CODE_MID_HIGH) ||
                 (a == {1'b0, CODE_MID_HIGH} && b == CODE_MID_LOW))
            r = POS_MID;
        else if ((a == {1'b0, CODE_MID_HIGH} && b == CODE_TOP) ||
                 (a == {1'b0, CODE_TOP} && b == CODE_MID_HIGH))
            r = POS_TOP;
        return r;
    endfunction

endpackage

// ===== rtl/eapc_core.sv =====
// Controller state and single-pass tick update: debounce, faults, position, target, pause, motor phases.
`include "assert_macros.svh"
module eapc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  eapc_pkg::item_t  item,
    input  eapc_pkg::cfg_t   cfg,
    output eapc_pkg::result_t result
);
    import eapc_pkg::*;

    logic [1:0]  debounce_code_reg, debounce_code_next;
    logic [3:0]  debounce_count_reg, debounce_count_next;
    logic [1:0]  filtered_code_reg, filtered_code_next;
    logic [1:0]  monitored_code_reg, monitored_code_next;
    logic [2:0]  edge_history_reg, edge_history_next;
    logic [1:0]  position_reg, position_next;
    logic [1:0]  target_reg, target_next;
    logic [15:0] lost_timer_reg, lost_timer_next;
    logic [15:0] oc_timer_reg, oc_timer_next;
    action_t     action_reg, action_next;
    logic [2:0]  last_action_reg, last_action_next;
    logic [13:0] phase_timer_reg, phase_timer_next;
    logic [9:0]  pwm_reg, pwm_next;
    logic [4:0]  pause_count_reg, pause_count_next;
    logic        run_reg, run_next;
    logic        dir_reg, dir_next;
    logic        top_reg, top_next;
    logic        bot_reg, bot_next;
    logic        homed_reg, homed_next;
    logic        lock_reg, lock_next;
    logic        sens_reg, sens_next;
    logic        ocf_reg, ocf_next;

    logic        homed_req;
    logic [1:0]  pos_req;
    logic [1:0]  pos_new;
    logic [1:0]  code;
    logic [1:0]  edge_pos;
    action_t     act_chk;
    action_t     act_req;
    logic [13:0] tick_ext;
    logic [13:0] phase_base;
    logic [13:0] phase_run;
    logic [10:0] pwm_sum;

    always_comb
    begin
        target_next = item.set_target ? item.target_position : target_reg;
        homed_req   = homed_reg;
        pos_req     = position_reg;
        if (item.restart_homing)
        begin
            homed_req   = 1'b0;
            target_next = POS_BOTTOM;
            pos_req     = POS_TOP;
        end
        pause_count_next = pause_count_reg;
        if (item.pause_event == PAUSE_ON && pause_count_reg < PAUSE_MAX)
            pause_count_next = pause_count_reg + 5'd1;
        else if (item.pause_event == PAUSE_OFF && pause_count_reg != 5'd0)
            pause_count_next = pause_count_reg - 5'd1;

        // debounce
        debounce_code_next  = debounce_code_reg;
        debounce_count_next = debounce_count_reg;
        filtered_code_next  = filtered_code_reg;
        if (debounce_code_reg != item.encoder_code)
        begin
            debounce_count_next = 4'd0;
            debounce_code_next  = item.encoder_code;
        end
        else if (debounce_count_reg < STABLE_TICKS)
            debounce_count_next = debounce_count_reg + 4'd1;
        else
            filtered_code_next = debounce_code_reg;
        code = filtered_code_next;

        // sensor loss
        lost_timer_next = 16'd0;
        sens_next       = sens_reg;
        if (monitored_code_reg == code && run_reg)
        begin
            if (lost_timer_reg <= cfg.sensor_lost_ms)
                lost_timer_next = sat16_add(lost_timer_reg, cfg.tick_ms);
            else
            begin
                lost_timer_next = lost_timer_reg;
                sens_next       = 1'b1;
            end
        end

        // position decode
        pos_new  = pos_req;
        edge_pos = edge_position(edge_history_reg, code);
        top_next = 1'b0;
        bot_next = 1'b0;
        if (code == CODE_BOTTOM)
        begin
            pos_new  = POS_BOTTOM;
            bot_next = 1'b1;
        end
        else if (code == CODE_TOP)
        begin
            pos_new  = POS_TOP;
            top_next = 1'b1;
        end
        else if (edge_history_reg != {1'b0, code} && edge_pos != EDGE_NONE)
            pos_new = edge_pos;
        edge_history_next   = {1'b0, code};
        position_next       = pos_new;
        homed_next          = homed_req | (pos_new == POS_BOTTOM);
        monitored_code_next = code;

        act_chk = action_reg;
        if (((action_reg == ACT_UP && top_next) || (action_reg == ACT_DOWN && bot_next)) &&
            !lock_reg)
            act_chk = ACT_STOP;

        // over-current
        oc_timer_next = 16'd0;
        ocf_next      = ocf_reg;
        if (item.over_current_active)
        begin
            if (oc_timer_reg <= cfg.overcurrent_ms)
                oc_timer_next = sat16_add(oc_timer_reg, cfg.tick_ms);
            else
            begin
                oc_timer_next = oc_timer_reg;
                ocf_next      = 1'b1;
            end
        end

        // target selection
        priority if (!homed_next)
            act_req = ACT_DOWN;
        else if (target_next == TARGET_KEEP)
            act_req = ACT_STOP;
        else if (target_next == POS_BOTTOM)
            act_req = bot_next ? ACT_STOP : ACT_DOWN;
        else if (target_next == POS_TOP)
            act_req = top_next ? ACT_STOP : ACT_UP;
        else if (target_next == pos_new)
            act_req = ACT_STOP;
        else if (target_next > pos_new)
            act_req = ACT_UP;
        else
            act_req = ACT_DOWN;

        action_next = act_chk;
        if (!((act_req == ACT_UP && top_next) || (act_req == ACT_DOWN && bot_next) ||
              lock_reg))
            action_next = act_req;

        // motor phases
        tick_ext         = {6'd0, cfg.tick_ms};
        run_next         = run_reg;
        dir_next         = dir_reg;
        pwm_next         = pwm_reg;
        lock_next        = lock_reg;
        last_action_next = last_action_reg;
        phase_base       = phase_timer_reg;
        if (last_action_reg != {1'b0, action_next})
        begin
            run_next = 1'b0;
            if (last_action_reg != {1'b0, ACT_STOP})
                phase_base = 14'd0;
            last_action_next = {1'b0, action_next};
        end
        phase_run        = (phase_base < PHASE_CAP) ? phase_base + tick_ext : phase_base;
        pwm_sum          = {1'b0, pwm_reg} + {1'b0, cfg.pwm_ramp_step};
        phase_timer_next = phase_base;
        if (pause_count_next != 5'd0)
        begin
            run_next = 1'b0;
            pwm_next = cfg.pwm_start;
        end
        else if (sens_next || ocf_next)
        begin
            lock_next        = 1'b1;
            run_next         = 1'b0;
            phase_timer_next = 14'd0;
        end
        else if (action_next != ACT_STOP)
        begin
            phase_timer_next = phase_run;
            if (phase_run <= {1'b0, cfg.dead_time_ms})
            begin
                run_next = 1'b0;
                pwm_next = 10'd0;
            end
            else if (phase_run <= {1'b0, cfg.reverse_ms})
            begin
                dir_next = (action_next == ACT_UP);
                pwm_next = cfg.pwm_start;
            end
            else
            begin
                run_next = 1'b1;
                if (pwm_reg < cfg.pwm_full)
                    pwm_next = pwm_sum[10] ? 10'h3FF : pwm_sum[9:0];
                else
                    pwm_next = cfg.pwm_full;
            end
        end
        else
        begin
            run_next = 1'b0;
            if (phase_base < {1'b0, cfg.dead_time_ms})
                phase_timer_next = phase_base + tick_ext;
        end
    end

    always_comb
    begin
        result.motor_on          = run_next;
        result.drive_up          = dir_next;
        result.pwm_duty          = pwm_next;
        result.position_now      = position_next;
        result.at_top            = top_next;
        result.at_bottom         = bot_next;
        result.homed             = homed_next;
        result.locked            = lock_next;
        result.sensor_fault      = sens_next;
        result.overcurrent_fault = ocf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_code_reg  <= 2'd0;
            debounce_count_reg <= 4'd0;
            filtered_code_reg  <= CODE_TOP;
            monitored_code_reg <= 2'd0;
            edge_history_reg   <= HISTORY_NONE;
            position_reg       <= POS_TOP;
            target_reg         <= POS_BOTTOM;
            lost_timer_reg     <= 16'd0;
            oc_timer_reg       <= 16'd0;
            action_reg         <= ACT_STOP;
            last_action_reg    <= LAST_NONE;
            phase_timer_reg    <= 14'd0;
            pwm_reg            <= 10'd0;
            pause_count_reg    <= 5'd0;
            run_reg            <= 1'b0;
            dir_reg            <= 1'b0;
            top_reg            <= 1'b0;
            bot_reg            <= 1'b0;
            homed_reg          <= 1'b0;
            lock_reg           <= 1'b0;
            sens_reg           <= 1'b0;
            ocf_reg            <= 1'b0;
        end
        else if (step)
        begin
            debounce_code_reg  <= debounce_code_next;
            debounce_count_reg <= debounce_count_next;
            filtered_code_reg  <= filtered_code_next;
            monitored_code_reg <= monitored_code_next;
            edge_history_reg   <= edge_history_next;
            position_reg       <= position_next;
            target_reg         <= target_next;
            lost_timer_reg     <= lost_timer_next;
            oc_timer_reg       <= oc_timer_next;
            action_reg         <= action_next;
            last_action_reg    <= last_action_next;
            phase_timer_reg    <= phase_timer_next;
            pwm_reg            <= pwm_next;
            pause_count_reg    <= pause_count_next;
            run_reg            <= run_next;
            dir_reg            <= dir_next;
            top_reg            <= top_next;
            bot_reg            <= bot_next;
            homed_reg          <= homed_next;
            lock_reg           <= lock_next;
            sens_reg           <= sens_next;
            ocf_reg            <= ocf_next;
        end
    end

    `ASSERT_CLK(a_lock_stops_motor, clk, rst_n, lock_reg |-> !run_reg, "motor runs while locked")
    `ASSERT_CLK(a_lock_has_fault, clk, rst_n, lock_reg |-> (sens_reg || ocf_reg), "lock without fault")
    `ASSERT_NEVER(a_both_ends, clk, rst_n, top_reg && bot_reg, "top and bottom both set")
    `ASSERT_CLK(a_run_has_action, clk, rst_n, run_reg |-> (action_reg != ACT_STOP), "run while stopped")
    `ASSERT_CLK(a_homed_drop, clk, rst_n, $fell(homed_reg) |-> $past(step && item.restart_homing), "homed lost without rehome")

endmodule

// ===== rtl/encoded_actuator_position_controller.sv =====
// Top level: stream ports, configuration registers, input and result registers.
// One item is one timer tick and yields exactly one result item. The block takes one item per
// clock while the result register can drain: an accepted item sits in the input register, and the
// whole tick update runs in one pass from there into the result register. The input register
// can still take an item while a result waits on m_tready, and the input side stalls only once
// both registers are full. Configuration writes take effect at once.
`include "assert_macros.svh"
module encoded_actuator_position_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    // encoder_code[1:0], over_current_active[2], set_target[3], target_position[5:4],
    // pause_event[7:6], restart_homing[8], zero [15:9]
    input  logic [eapc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // motor_on[0], drive_up[1], pwm_duty[11:2], position_now[13:12], at_top[14],
    // at_bottom[15], homed[16], locked[17], sensor_fault[18], overcurrent_fault[19], zero [23:20]
    output logic [eapc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [2:0]                      cfg_index,
    input  logic [15:0]                     cfg_wdata
);
    import eapc_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t out_result_reg;
    logic    out_valid_reg, out_valid_next;
    result_t core_result;
    logic    advance;
    logic    in_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign in_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_result_reg};

    eapc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        if (advance)
            out_result_reg <= core_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms        <= 8'd10;
            cfg_reg.sensor_lost_ms <= 16'd3000;
            cfg_reg.overcurrent_ms <= 16'd500;
            cfg_reg.dead_time_ms   <= 13'd100;
            cfg_reg.reverse_ms     <= 13'd200;
            cfg_reg.pwm_start      <= 10'd300;
            cfg_reg.pwm_full       <= 10'd1023;
            cfg_reg.pwm_ramp_step  <= 10'd8;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TICK_MS:        cfg_reg.tick_ms        <= cfg_wdata[7:0];
                CFG_SENSOR_LOST_MS: cfg_reg.sensor_lost_ms <= cfg_wdata;
                CFG_OVERCURRENT_MS: cfg_reg.overcurrent_ms <= cfg_wdata;
                CFG_DEAD_TIME_MS:   cfg_reg.dead_time_ms   <= cfg_wdata[12:0];
                CFG_REVERSE_MS:     cfg_reg.reverse_ms     <= cfg_wdata[12:0];
                CFG_PWM_START:      cfg_reg.pwm_start      <= cfg_wdata[9:0];
                CFG_PWM_FULL:       cfg_reg.pwm_full       <= cfg_wdata[9:0];
                CFG_PWM_RAMP_STEP:  cfg_reg.pwm_ramp_step  <= cfg_wdata[9:0];
                default:            cfg_reg.tick_ms        <= cfg_reg.tick_ms;
            endcase
        end
    end

    `ASSERT_CLK(a_advance_fills_out, clk, rst_n, advance |=> out_valid_reg, "result slot not filled")
    `ASSERT_CLK(a_full_stalls_in, clk, rst_n, (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready, "input taken while both registers full")
    `ASSERT_CLK(a_out_holds, clk, rst_n, (out_valid_reg && !m_tready) |=> $stable(out_result_reg), "held result changed")

endmodule
